// ----- design/sst_pkg.sv -----
// Shared types, constants and op codes of the S-curve stepper step timer.
`timescale 1ns / 1ps

package sst_pkg;

	// Ramp table geometry.
	localparam int TABLE_DEPTH = 256;
	localparam int TABLE_AW    = 8;
	localparam int RAMP_W      = TABLE_AW + 1;

	// First table entry at or above this value ends the ramp.
	localparam logic [15:0] RAMP_THRESH = 16'd798;

	// Operation codes of an input transaction.
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_STOP  = 2'd3;

	// One input item.
	typedef struct packed {
		logic [1:0]         op;
		logic [7:0]         table_index;
		logic [15:0]        table_value;
		logic signed [31:0] target_position;
	} sst_in_t;

	// One result item.
	typedef struct packed {
		logic               step_strobe;
		logic               direction;
		logic [31:0]        period;
		logic               period_valid;
		logic signed [31:0] position;
		logic               move_done;
	} sst_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic load_wr;
		logic start;
		logic scan_rd;
		logic scan_cmp;
		logic tick;
		logic stop;
		logic div_init;
		logic div_step;
		logic out_load;
	} sst_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic       running;
		logic       ramp_zero;
		logic       scan_hit;
		logic       scan_last;
		logic       div_zero;
	} sst_sts_t;

endpackage

// ----- design/sst_dpath.sv -----
// Datapath: ramp table memory, move state, ramp scan and iterative period divider.
`timescale 1ns / 1ps

module sst_dpath (
	input  logic             clk,
	input  logic             arst_n,
	input  sst_pkg::sst_in_t cmd_data,
	input  logic             cfg_valid,
	input  logic [31:0]      cfg_data,
	input  sst_pkg::sst_cmd_t cmd,
	output sst_pkg::sst_sts_t sts,
	output sst_pkg::sst_out_t rsp_data
);
	import sst_pkg::*;

	logic [15:0]         mem [TABLE_DEPTH];
	sst_in_t             item_q;
	logic [31:0]         pos_q;
	logic [31:0]         steps_q;
	logic [31:0]         total_q;
	logic [RAMP_W-1:0]   ramp_q;
	logic [RAMP_W-1:0]   decel_q;
	logic                dir_q;
	logic                run_q;
	logic [31:0]         spd_q;
	logic [TABLE_AW-1:0] scan_q;
	logic [15:0]         rd_q;
	logic [16:0]         rem_q;
	logic [31:0]         quo_q;
	logic [15:0]         dvs_q;
	logic                pulse_q;
	logic                pvalid_q;
	sst_out_t            rsp_q;

	logic signed [32:0]  delta;
	logic [32:0]         mag;
	logic                accel;
	logic                cruise;
	logic                dec_room;
	logic [RAMP_W-1:0]   dec_idx;
	logic [RAMP_W-1:0]   tick_idx;
	logic [TABLE_AW-1:0] rd_addr;
	logic [32:0]         steps_inc;
	logic [16:0]         rem_sh;
	logic [17:0]         trial;
	sst_out_t            rsp_next;

	// Signed distance from the current position to the target.
	assign delta = $signed({item_q.target_position[31], item_q.target_position})
		- $signed({pos_q[31], pos_q});
	assign mag   = delta[32] ? (33'd0 - delta) : delta;

	// Phase of the current step and the table entry it uses.
	assign accel    = steps_q < {{(32-RAMP_W){1'b0}}, ramp_q};
	assign cruise   = ({1'b0, steps_q} + {{(33-RAMP_W){1'b0}}, ramp_q}) <= {1'b0, total_q};
	assign dec_room = decel_q < ramp_q;
	assign dec_idx  = dec_room ? (ramp_q - decel_q - RAMP_W'(1)) : '0;
	always_comb begin
		if (accel) begin
			tick_idx = steps_q[RAMP_W-1:0];
		end else if (cruise) begin
			tick_idx = ramp_q - RAMP_W'(1);
		end else begin
			tick_idx = dec_idx;
		end
	end
	assign rd_addr   = cmd.scan_rd ? scan_q : tick_idx[TABLE_AW-1:0];
	assign steps_inc = {1'b0, steps_q} + 33'd1;

	// One restoring division step.
	assign rem_sh = {rem_q[15:0], quo_q[31]};
	assign trial  = {1'b0, rem_sh} - {2'b00, dvs_q};

	// Status back to the controller.
	assign sts.op        = item_q.op;
	assign sts.running   = run_q;
	assign sts.ramp_zero = (ramp_q == '0);
	assign sts.scan_hit  = (rd_q >= RAMP_THRESH);
	assign sts.scan_last = (scan_q == TABLE_AW'(TABLE_DEPTH - 1));
	assign sts.div_zero  = (rd_q == 16'd0);

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			mem[item_q.table_index] <= item_q.table_value;
		end
		if (cmd.scan_rd || cmd.tick) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_q <= '0;
		end else if (cfg_valid) begin
			spd_q <= cfg_data;
		end
	end

	// Move state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			steps_q <= '0;
			total_q <= '0;
			ramp_q  <= '0;
			decel_q <= '0;
			dir_q   <= 1'b0;
			run_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				dir_q   <= delta[32];
				total_q <= mag[31:0];
				steps_q <= '0;
				decel_q <= '0;
				run_q   <= (mag[31:0] != 32'd0);
			end
			if (cmd.scan_cmp) begin
				if (sts.scan_hit) begin
					ramp_q <= {1'b0, scan_q};
				end else if (sts.scan_last) begin
					ramp_q <= RAMP_W'(TABLE_DEPTH);
				end
			end
			if (cmd.tick) begin
				pos_q   <= dir_q ? (pos_q - 32'd1) : (pos_q + 32'd1);
				steps_q <= steps_inc[31:0];
				if (steps_inc >= {1'b0, total_q}) begin
					run_q <= 1'b0;
				end
				if (!accel && !cruise && dec_room) begin
					decel_q <= decel_q + RAMP_W'(1);
				end
			end
			if (cmd.stop) begin
				run_q <= 1'b0;
			end
		end
	end

	// Item register, scan pointer, divider and per-item result flags.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q   <= cmd_data;
			pulse_q  <= 1'b0;
			pvalid_q <= 1'b0;
		end
		if (cmd.start) begin
			scan_q <= '0;
		end
		if (cmd.scan_cmp && !sts.scan_hit && !sts.scan_last) begin
			scan_q <= scan_q + TABLE_AW'(1);
		end
		if (cmd.tick) begin
			pulse_q  <= 1'b1;
			pvalid_q <= (ramp_q != '0);
		end
		if (cmd.div_init) begin
			dvs_q <= rd_q;
			rem_q <= '0;
			quo_q <= (rd_q == 16'd0) ? '1 : spd_q;
		end
		if (cmd.div_step) begin
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			rsp_q <= rsp_next;
		end
	end

	// Result assembled from the state after the item.
	always_comb begin
		rsp_next.step_strobe  = pulse_q;
		rsp_next.direction    = dir_q;
		rsp_next.period       = pvalid_q ? quo_q : 32'd0;
		rsp_next.period_valid = pvalid_q;
		rsp_next.position     = pos_q;
		rsp_next.move_done    = !run_q;
	end
	assign rsp_data = rsp_q;

	// A running move always has steps left to issue.
	a_run_steps: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (steps_q < total_q))
		else $error("running with no steps left");

	// The deceleration walk never passes the ramp length.
	a_decel_bound: assert property (@(posedge clk) disable iff (!arst_n)
		decel_q <= ramp_q)
		else $error("decel count beyond ramp length");

	// The ramp length never exceeds the table depth.
	a_ramp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_q <= RAMP_W'(TABLE_DEPTH))
		else $error("ramp length beyond table depth");

endmodule

// ----- design/sst_ctrl.sv -----
// Controller: sequences load, start scan, step tick, stop, divider and result hand-off.
`timescale 1ns / 1ps

module sst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  sst_pkg::sst_sts_t sts,
	output sst_pkg::sst_cmd_t cmd
);
	import sst_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DECODE   = 3'd1;
	localparam logic [2:0] S_SCAN_RD  = 3'd2;
	localparam logic [2:0] S_SCAN_CMP = 3'd3;
	localparam logic [2:0] S_DIV_INIT = 3'd4;
	localparam logic [2:0] S_DIV      = 3'd5;
	localparam logic [2:0] S_FINISH   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [4:0] cnt_q;
	logic       rsp_valid_q;
	logic       slot_free;

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					OP_LOAD: begin
						cmd.load_wr = 1'b1;
						state_d     = S_FINISH;
					end
					OP_START: begin
						cmd.start = 1'b1;
						state_d   = S_SCAN_RD;
					end
					OP_TICK: begin
						if (sts.running) begin
							cmd.tick = 1'b1;
							state_d  = sts.ramp_zero ? S_FINISH : S_DIV_INIT;
						end else begin
							state_d = S_FINISH;
						end
					end
					default: begin
						cmd.stop = 1'b1;
						state_d  = S_FINISH;
					end
				endcase
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				cmd.scan_cmp = 1'b1;
				state_d      = (sts.scan_hit || sts.scan_last) ? S_FINISH : S_SCAN_RD;
			end
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = sts.div_zero ? S_FINISH : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '1) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, divider step count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 5'd1;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// A new result never overwrites one that is still held by the receiver.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> slot_free)
		else $error("result register overwritten while stalled");

endmodule

// ----- design/stepper_s_curve_step_timer.sv -----
// Top level of the S-curve stepper step timer: controller plus datapath.
//
// Input channel (cmd_valid / cmd_stall / cmd_data): one transaction per
// operation: load a ramp table entry, start a move to an absolute target,
// step tick, or stop. Output channel (rsp_valid / rsp_stall / rsp_data):
// exactly one result per input transaction, in order.
// Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the speed
// numerator; it is always ready. It is to be written only while the block
// is idle; the block itself does not enforce this. A tick during a move
// runs the bit-serial 32-step restoring divider, which is skipped with a
// zero ramp or a zero table entry; a start scans table entries in order
// through the single table read port. The next transaction is accepted
// once the result has moved into the output register, even if the
// receiver stalls.
// A stalled result holds its value until taken; while it is held, the next
// transaction runs but waits before its own result is written.
// Reset clears the position, move state and speed numerator; the table
// holds no defined values until loaded.
`timescale 1ns / 1ps

module stepper_s_curve_step_timer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  sst_pkg::sst_in_t  cmd_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output sst_pkg::sst_out_t rsp_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data
);
	import sst_pkg::*;

	sst_cmd_t cmd;
	sst_sts_t sts;

	// Configuration writes land in a single register, so they are never held off.
	assign cfg_ready = 1'b1;

	sst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sst_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_data  (cmd_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_data  (rsp_data)
	);

endmodule
